[rtl/core/teg_pkg.sv]
`timescale 1ns / 1ps
package teg_pkg;

  localparam int COORD_BITS = 16;
  localparam int EFF_BITS   = (COORD_BITS > 16) ? 16 : ((COORD_BITS < 2) ? 2 : COORD_BITS);

  localparam int DIFF_W = 17;              // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;      // one cross product
  localparam int DET_W  = PROD_W + 1;      // full determinant
  localparam int OUT_DET_W = 34;
  localparam int NUM_W  = DIFF_W + 25;     // 2*|diff|*2^24 + |det|
  localparam int DEN_W  = DET_W;           // 2*|det|
  localparam int SQ_W   = NUM_W + 1;       // signed quotient
  localparam int SUM_W  = SQ_W + 1;
  localparam int GRAD_W = 32;
  localparam int LAT    = 4 + NUM_W + 2;   // start to out_valid

  typedef logic signed [DIFF_W-1:0] diff_t;

  function automatic logic signed [15:0] coord_of(input logic [15:0] raw);
    logic [15:0] sh;
    sh = raw << (16 - EFF_BITS);
    return $signed(sh) >>> (16 - EFF_BITS);
  endfunction

  // {clamped flag, clamped value}
  function automatic logic [GRAD_W:0] clamp32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sd2147483647);
    lo = -SUM_W'(64'sd2147483648);
    if (v > hi) return {1'b1, 1'b0, {(GRAD_W-1){1'b1}}};
    if (v < lo) return {1'b1, 1'b1, {(GRAD_W-1){1'b0}}};
    return {1'b0, v[GRAD_W-1:0]};
  endfunction

endpackage

[rtl/core/teg_div.sv]
`timescale 1ns / 1ps
module teg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [teg_pkg::NUM_W-1:0]  in_num,
  input  logic [teg_pkg::DEN_W-1:0]  in_den,
  input  logic                       in_neg,
  output logic                       out_vld,
  output logic [teg_pkg::NUM_W-1:0]  out_quo,
  output logic                       out_neg
);
  import teg_pkg::*;

  logic             vld_r [NUM_W];
  logic             neg_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [NUM_W-1:0] num_in, quo_in;
    logic [DEN_W-1:0] den_in, rem_in;
    logic             vld_in, neg_in;
    logic [DEN_W:0]   trial;
    logic             take;
    logic [DEN_W:0]   diff;

    if (i == 0) begin : g_first
      assign num_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign rem_in = '0;
      assign vld_in = in_vld;
      assign neg_in = in_neg;
    end else begin : g_next
      assign num_in = num_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
      assign rem_in = rem_r[i-1];
      assign vld_in = vld_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign take  = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      neg_r[i] <= neg_in;
      den_r[i] <= den_in;
      num_r[i] <= {num_in[NUM_W-2:0], 1'b0};
      quo_r[i] <= {quo_in[NUM_W-2:0], take};
      rem_r[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign out_vld = vld_r[NUM_W-1];
  assign out_quo = quo_r[NUM_W-1];
  assign out_neg = neg_r[NUM_W-1];

  // the remainder never reaches the divisor
  a_rem_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_W-1] && (den_r[NUM_W-1] != '0) |-> rem_r[NUM_W-1] < den_r[NUM_W-1])
    else $error("divider remainder not below divisor");
  a_vld_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> $past(vld_r[NUM_W-2]))
    else $error("divider valid out of step");
  a_neg_flow: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> neg_r[1] == $past(neg_r[0]))
    else $error("divider sign lost");

endmodule

[rtl/core/triangle_element_gradients.sv]
`timescale 1ns / 1ps
// Linear triangle shape-function gradients.
// Raise start with the three vertices on in_node*_x / in_node*_y (signed Q7.8);
// the triangle transfers at the edge where start is high and busy is low.
// busy stays low: a new triangle may transfer on every cycle.
// Each result appears on the out_ ports for one cycle with out_valid high,
// in issue order, after 48 register stages, the first loaded at the start edge:
// four of difference, product and divider setup, 42 of the restoring divider
// (one quotient bit per stage, four dividers side by side), then two of sign
// fix-up, node one summation and clamping. out_jacobian_det is twice the
// signed area in Q17.16; gradients are Q15.16, clamped with out_saturated
// set. A zero determinant gives zero gradients and out_degenerate.
// The receiver cannot stall: out_valid pulses must be taken when they occur.
// Synchronous reset clears all valid bits; items in flight are dropped.
module triangle_element_gradients (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [15:0]                       in_node1_x,
  input  logic [15:0]                       in_node1_y,
  input  logic [15:0]                       in_node2_x,
  input  logic [15:0]                       in_node2_y,
  input  logic [15:0]                       in_node3_x,
  input  logic [15:0]                       in_node3_y,
  output logic                              out_valid,
  output logic [teg_pkg::OUT_DET_W-1:0]     out_jacobian_det,
  output logic [teg_pkg::GRAD_W-1:0]        out_grad1_x,
  output logic [teg_pkg::GRAD_W-1:0]        out_grad1_y,
  output logic [teg_pkg::GRAD_W-1:0]        out_grad2_x,
  output logic [teg_pkg::GRAD_W-1:0]        out_grad2_y,
  output logic [teg_pkg::GRAD_W-1:0]        out_grad3_x,
  output logic [teg_pkg::GRAD_W-1:0]        out_grad3_y,
  output logic                              out_degenerate,
  output logic                              out_saturated
);
  import teg_pkg::*;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: differences
  logic  s1_vld_r;
  diff_t a_r, b_r, c_r, e_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    a_r <= DIFF_W'(coord_of(in_node2_x)) - DIFF_W'(coord_of(in_node1_x));
    b_r <= DIFF_W'(coord_of(in_node3_y)) - DIFF_W'(coord_of(in_node1_y));
    c_r <= DIFF_W'(coord_of(in_node2_y)) - DIFF_W'(coord_of(in_node1_y));
    e_r <= DIFF_W'(coord_of(in_node3_x)) - DIFF_W'(coord_of(in_node1_x));
  end

  // stage 2: cross products
  logic s2_vld_r;
  logic signed [PROD_W-1:0] p1_r, p2_r;
  diff_t a2_r, b2_r, c2_r, e2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    p1_r <= a_r * b_r;
    p2_r <= c_r * e_r;
    a2_r <= a_r;
    b2_r <= b_r;
    c2_r <= c_r;
    e2_r <= e_r;
  end

  // stage 3: determinant
  logic s3_vld_r;
  logic signed [DET_W-1:0] det_r;
  diff_t a3_r, b3_r, c3_r, e3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    det_r <= DET_W'(p1_r) - DET_W'(p2_r);
    a3_r  <= a2_r;
    b3_r  <= b2_r;
    c3_r  <= c2_r;
    e3_r  <= e2_r;
  end

  // stage 4: divider operands, dividend 2*|d|*2^24 + |det|, divisor 2*|det|
  logic [DET_W-1:0] det_mag;
  diff_t            dv [4];
  logic [NUM_W-1:0] num_nxt [4];
  logic             neg_nxt [4];
  assign det_mag = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  assign dv[0] = b3_r;
  assign dv[1] = -e3_r;
  assign dv[2] = -c3_r;
  assign dv[3] = a3_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [DIFF_W-1:0] m;
      m = dv[k][DIFF_W-1] ? DIFF_W'(-dv[k]) : DIFF_W'(dv[k]);
      num_nxt[k] = (NUM_W'(m) << 25) + NUM_W'(det_mag);
      neg_nxt[k] = dv[k][DIFF_W-1] ^ det_r[DET_W-1];
    end
  end

  logic             s4_vld_r;
  logic [NUM_W-1:0] num_r [4];
  logic             neg_r [4];
  logic [DEN_W-1:0] den_r;
  logic signed [DET_W-1:0] det4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    for (int k = 0; k < 4; k++) begin
      num_r[k] <= num_nxt[k];
      neg_r[k] <= neg_nxt[k];
    end
    den_r  <= {det_mag[DEN_W-2:0], 1'b0};
    det4_r <= det_r;
  end

  // dividers and matching determinant delay line
  logic             dv_vld [4];
  logic [NUM_W-1:0] dv_quo [4];
  logic             dv_neg [4];
  for (genvar k = 0; k < 4; k++) begin : g_div
    teg_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (s4_vld_r),
      .in_num  (num_r[k]),
      .in_den  (den_r),
      .in_neg  (neg_r[k]),
      .out_vld (dv_vld[k]),
      .out_quo (dv_quo[k]),
      .out_neg (dv_neg[k])
    );
  end

  logic signed [DET_W-1:0] det_d_r [NUM_W];
  always_ff @(posedge clk) begin
    det_d_r[0] <= det4_r;
    for (int i = 1; i < NUM_W; i++) det_d_r[i] <= det_d_r[i-1];
  end

  // stage 5: apply signs
  logic                    s5_vld_r;
  logic signed [SQ_W-1:0]  q_r [4];
  logic signed [DET_W-1:0] det5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= dv_vld[0];
    end
    for (int k = 0; k < 4; k++)
      q_r[k] <= dv_neg[k] ? -$signed({1'b0, dv_quo[k]}) : $signed({1'b0, dv_quo[k]});
    det5_r <= det_d_r[NUM_W-1];
  end

  // stage 6: node one, clamp, output
  logic [GRAD_W:0] cl [6];
  logic            deg;
  logic            sat;
  assign deg   = (det5_r == '0);
  assign cl[0] = clamp32(-(SUM_W'(q_r[0]) + SUM_W'(q_r[2])));
  assign cl[1] = clamp32(-(SUM_W'(q_r[1]) + SUM_W'(q_r[3])));
  assign cl[2] = clamp32(SUM_W'(q_r[0]));
  assign cl[3] = clamp32(SUM_W'(q_r[1]));
  assign cl[4] = clamp32(SUM_W'(q_r[2]));
  assign cl[5] = clamp32(SUM_W'(q_r[3]));
  assign sat   = !deg && (cl[0][GRAD_W] || cl[1][GRAD_W] || cl[2][GRAD_W] ||
                          cl[3][GRAD_W] || cl[4][GRAD_W] || cl[5][GRAD_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s5_vld_r;
    end
    out_jacobian_det <= det5_r[OUT_DET_W-1:0];
    out_grad1_x      <= deg ? '0 : cl[0][GRAD_W-1:0];
    out_grad1_y      <= deg ? '0 : cl[1][GRAD_W-1:0];
    out_grad2_x      <= deg ? '0 : cl[2][GRAD_W-1:0];
    out_grad2_y      <= deg ? '0 : cl[3][GRAD_W-1:0];
    out_grad3_x      <= deg ? '0 : cl[4][GRAD_W-1:0];
    out_grad3_y      <= deg ? '0 : cl[5][GRAD_W-1:0];
    out_degenerate   <= deg;
    out_saturated    <= sat;
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching transfer");
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_grad1_x == '0 && out_grad2_y == '0 &&
      out_jacobian_det == '0 && !out_saturated)
    else $error("degenerate result not cleared");
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[0] == dv_vld[3])
    else $error("divider lanes out of step");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import teg_pkg::*;

  typedef struct packed {
    logic [33:0] det;
    logic [31:0] g1x, g1y, g2x, g2y, g3x, g3y;
    logic        degen;
    logic        sat;
  } grad_result_t;

  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] n1x = '0, n1y = '0, n2x = '0, n2y = '0, n3x = '0, n3y = '0;
  logic out_valid;
  logic [OUT_DET_W-1:0] out_det;
  logic [GRAD_W-1:0] o1x, o1y, o2x, o2y, o3x, o3y;
  logic out_degen, out_sat;

  grad_result_t pending_grads[$];
  int errors = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  triangle_element_gradients DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_node1_x(n1x), .in_node1_y(n1y), .in_node2_x(n2x),
    .in_node2_y(n2y), .in_node3_x(n3x), .in_node3_y(n3y),
    .out_valid(out_valid), .out_jacobian_det(out_det),
    .out_grad1_x(o1x), .out_grad1_y(o1y), .out_grad2_x(o2x),
    .out_grad2_y(o2y), .out_grad3_x(o3x), .out_grad3_y(o3y),
    .out_degenerate(out_degen), .out_saturated(out_sat)
  );

  function automatic longint sext_coord(logic [15:0] raw);
    logic [15:0] v;
    v = raw << (16 - EFF_BITS);
    return longint'($signed(v) >>> (16 - EFF_BITS));
  endfunction

  // round(d * 2^24 / den), ties away from zero
  function automatic longint div_q16(longint d, longint den);
    logic [127:0] nm, dm, q;
    nm = (d < 0 ? -d : d);
    nm = nm << 24;
    dm = (den < 0 ? -den : den);
    q = (2 * nm + dm) / (2 * dm);
    return ((d < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] sat32(longint v, inout logic s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic grad_result_t triangle_grads(logic [15:0] a, b, c, d, e, f);
    longint x1, y1, x2, y2, x3, y3, det, g2x, g2y, g3x, g3y;
    grad_result_t r;
    logic s;
    x1 = sext_coord(a); y1 = sext_coord(b);
    x2 = sext_coord(c); y2 = sext_coord(d);
    x3 = sext_coord(e); y3 = sext_coord(f);
    det = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
    r = '0;
    s = 1'b0;
    r.det = det[33:0];
    r.degen = (det == 0);
    if (det != 0) begin
      g2x = div_q16(y3 - y1, det);
      g2y = div_q16(x1 - x3, det);
      g3x = div_q16(y1 - y2, det);
      g3y = div_q16(x2 - x1, det);
      r.g1x = sat32(-(g2x + g3x), s);
      r.g1y = sat32(-(g2y + g3y), s);
      r.g2x = sat32(g2x, s);
      r.g2y = sat32(g2y, s);
      r.g3x = sat32(g3x, s);
      r.g3y = sat32(g3y, s);
    end
    r.sat = s;
    return r;
  endfunction

  task automatic send_triangle(logic [15:0] a, b, c, d, e, f);
    n1x <= a; n1y <= b; n2x <= c; n2y <= d; n3x <= e; n3y <= f;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_grads.push_back(triangle_grads(a, b, c, d, e, f));
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // tight triangles, big gradients
  task automatic send_small_triangle();
    logic [15:0] bx, by;
    bx = 16'($urandom);
    by = 16'($urandom);
    send_triangle(bx, by, bx + 16'($urandom_range(0, 3)), by + 16'($urandom_range(0, 3)),
                  bx + 16'($urandom_range(0, 3)), by + 16'($urandom_range(0, 3)));
  endtask

  task automatic test_directed();
    send_triangle(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
    send_triangle(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000);
    send_triangle(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_triangle(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_triangle(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_triangle('0, '0, '0, '0, '0, '0);
    send_triangle(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h0300, 16'h0300);
    send_triangle(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_triangle(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
    send_triangle(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'hffff);
    send_triangle(16'h0000, 16'h0000, 16'h0002, 16'h0001, 16'h0001, 16'h0002);
    send_triangle(16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 16'h0003);
    send_triangle(16'h1234, 16'hfedc, 16'h1235, 16'hfedc, 16'h1234, 16'hfedd);
    send_triangle(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    start <= 1'b0;
  endtask

  task automatic test_random();
    int sel;
    repeat (550) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)
        send_triangle(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
      else if (sel < 8)
        send_small_triangle();
      else begin
        logic [15:0] ax, ay, dx, dy;
        ax = 16'($urandom); ay = 16'($urandom);
        dx = 16'($urandom_range(0, 64)); dy = 16'($urandom_range(0, 64));
        // collinear
        send_triangle(ax, ay, ax + dx, ay + dy, ax - dx, ay - dy);
      end
      idle_gap();
    end
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    grad_result_t got, exp;
    if (rst_n && out_valid) begin
      got = '{out_det, o1x, o1y, o2x, o2y, o3x, o3y, out_degen, out_sat};
      if (pending_grads.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp = pending_grads.pop_front();
        if (got.det !== exp.det) begin
          $display("%0t: det exp %h got %h", $time, exp.det, got.det); errors++;
        end
        if (got.g1x !== exp.g1x) begin
          $display("%0t: grad1_x exp %h got %h", $time, exp.g1x, got.g1x); errors++;
        end
        if (got.g1y !== exp.g1y) begin
          $display("%0t: grad1_y exp %h got %h", $time, exp.g1y, got.g1y); errors++;
        end
        if (got.g2x !== exp.g2x) begin
          $display("%0t: grad2_x exp %h got %h", $time, exp.g2x, got.g2x); errors++;
        end
        if (got.g2y !== exp.g2y) begin
          $display("%0t: grad2_y exp %h got %h", $time, exp.g2y, got.g2y); errors++;
        end
        if (got.g3x !== exp.g3x) begin
          $display("%0t: grad3_x exp %h got %h", $time, exp.g3x, got.g3x); errors++;
        end
        if (got.g3y !== exp.g3y) begin
          $display("%0t: grad3_y exp %h got %h", $time, exp.g3y, got.g3y); errors++;
        end
        if (got.degen !== exp.degen) begin
          $display("%0t: degenerate exp %b got %b", $time, exp.degen, got.degen); errors++;
        end
        if (got.sat !== exp.sat) begin
          $display("%0t: saturated exp %b got %b", $time, exp.sat, got.sat); errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    while (pending_grads.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
